/* hw/rtl/mhd_pkg.sv */
// shared types and constants of the message header deframer
package mhd_pkg;

  localparam int unsigned HDR_BYTES   = 24;
  localparam int unsigned HDR_WORDS   = 6;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned WORD_IDX_W  = 3;
  localparam int unsigned DATA_W      = HDR_WORDS * WORD_W + BYTE_W;  // 200, whole bytes
  localparam int unsigned LEN_WORD    = 3;
  localparam int unsigned MAGIC_WORD  = 5;

  localparam logic [POS_W-1:0] LAST_HDR_POS = POS_W'(HDR_BYTES - 1);

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  typedef logic [WORD_W-1:0] word_t;

  // one result transfer as it travels to the output stage
  typedef struct packed {
    kind_t             kind;
    logic              last;
    logic [DATA_W-1:0] data;
  } result_t;

endpackage

/* hw/rtl/message_header_deframer.sv */
// top level of the message header deframer
//
// Takes a byte stream on the in_ channel, one byte per transfer. The first
// 24 bytes of a message are gathered as six little-endian 32-bit words:
// command, two arguments, payload length, checksum and magic. The 24th byte
// produces one header result (out_tuser = 0) carrying all six words; it has
// out_tlast set when the payload length is zero. Each following payload byte
// produces one result (out_tuser = 1) with the byte in the top of out_tdata,
// and the final one has out_tlast set. Then the next header is collected.
// Checksum and magic are passed on unchecked.
// One byte is taken per cycle while in_tready is high. Each result is registered
// in the output register, or in the skid stage while the receiver stalls.
// The output register is followed by a skid stage, so one more result is
// taken in after the receiver stalls; in_tready drops once both hold a
// result and rises again in the cycle after the receiver takes one.
// Reset clears the header position and payload state, so the first byte
// after reset starts a new header.
module message_header_deframer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // data_byte
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // command, first_argument, second_argument, payload_length, checksum_word,
  // magic_word, payload_byte
  output logic [mhd_pkg::DATA_W-1:0] out_tdata,
  output logic [0:0]                 out_tuser,  // kind
  output logic                       out_tlast   // last
);

  logic [mhd_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                       in_payload_r, in_payload_nxt;
  logic [mhd_pkg::WORD_W-1:0] remain_r, remain_nxt;
  mhd_pkg::word_t             words_r [mhd_pkg::HDR_WORDS];

  logic                           accept;
  logic                           buf_full;
  logic [mhd_pkg::POS_W-1:0]      pos_eff;
  logic [mhd_pkg::WORD_IDX_W-1:0] word_idx;
  logic [1:0]                     lane;
  mhd_pkg::word_t                 merged_word;
  mhd_pkg::word_t                 hdr_len;
  logic                           push;
  mhd_pkg::result_t               push_res;
  mhd_pkg::result_t               out_res;

  assign in_tready = !buf_full;
  assign accept    = in_tvalid && in_tready;

  // a position past the header is treated as the start of one
  assign pos_eff  = (pos_r > mhd_pkg::LAST_HDR_POS) ? '0 : pos_r;
  assign word_idx = pos_eff[mhd_pkg::POS_W-1:2];
  assign lane     = pos_eff[1:0];

  always_comb begin
    merged_word = words_r[word_idx];
    case (lane)
      2'd0:    merged_word[7:0]   = in_tdata;
      2'd1:    merged_word[15:8]  = in_tdata;
      2'd2:    merged_word[23:16] = in_tdata;
      2'd3:    merged_word[31:24] = in_tdata;
      default: merged_word        = words_r[word_idx];
    endcase
  end

  assign hdr_len = words_r[mhd_pkg::LEN_WORD];

  // next state
  always_comb begin
    pos_nxt        = pos_r;
    in_payload_nxt = in_payload_r;
    remain_nxt     = remain_r;
    if (accept) begin
      if (in_payload_r) begin
        remain_nxt = remain_r - 32'd1;
        if (remain_r == 32'd1) begin
          in_payload_nxt = 1'b0;
        end
      end else if (pos_eff == mhd_pkg::LAST_HDR_POS) begin
        pos_nxt        = '0;
        remain_nxt     = hdr_len;
        in_payload_nxt = (hdr_len != '0);
      end else begin
        pos_nxt = pos_eff + 5'd1;
      end
    end
  end

  // result for the byte being transferred
  always_comb begin
    push_res = '0;
    push     = 1'b0;
    if (accept) begin
      if (in_payload_r) begin
        push          = 1'b1;
        push_res.kind = mhd_pkg::KIND_PAYLOAD;
        push_res.last = (remain_r == 32'd1);
        push_res.data[mhd_pkg::DATA_W-1 -: mhd_pkg::BYTE_W] = in_tdata;
      end else if (pos_eff == mhd_pkg::LAST_HDR_POS) begin
        push          = 1'b1;
        push_res.kind = mhd_pkg::KIND_HEADER;
        push_res.last = (hdr_len == '0);
        for (int i = 0; i < int'(mhd_pkg::MAGIC_WORD); i++) begin
          push_res.data[i*mhd_pkg::WORD_W +: mhd_pkg::WORD_W] = words_r[i];
        end
        push_res.data[mhd_pkg::MAGIC_WORD*mhd_pkg::WORD_W +: mhd_pkg::WORD_W] = merged_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      in_payload_r <= 1'b0;
      remain_r     <= '0;
    end else begin
      pos_r        <= pos_nxt;
      in_payload_r <= in_payload_nxt;
      remain_r     <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_payload_r) begin
      words_r[word_idx] <= merged_word;
    end
  end

  mhd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .full      (buf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

/* hw/rtl/mhd_out_buf.sv */
// output register with a skid stage for the result channel
module mhd_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mhd_pkg::result_t push_res,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output mhd_pkg::result_t out_res
);

  logic             main_valid_r;
  logic             skid_valid_r;
  mhd_pkg::result_t main_res_r;
  mhd_pkg::result_t skid_res_r;

  // push never comes while the skid stage is occupied
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_ready) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_ready) begin
      main_res_r <= skid_valid_r ? skid_res_r : push_res;
    end else if (push) begin
      skid_res_r <= push_res;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_res_r;

endmodule

/* hw/rtl/mhd_checker.sv */
// port-level checks of the message header deframer and their binding
module mhd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [mhd_pkg::DATA_W-1:0] out_tdata,
  input logic [0:0]                 out_tuser,
  input logic                       out_tlast
);

  localparam int unsigned LEN_LSB = mhd_pkg::LEN_WORD * mhd_pkg::WORD_W;
  localparam int unsigned HDR_BITS = mhd_pkg::HDR_WORDS * mhd_pkg::WORD_W;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("result changed while stalled");

  // input only backs up behind a waiting result
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && $past(out_tvalid) && !$past(out_tready))
    else $error("input stalled without a stalled result");

  // header result is last exactly for an empty payload
  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == mhd_pkg::KIND_HEADER |->
      out_tlast == (out_tdata[LEN_LSB +: mhd_pkg::WORD_W] == '0))
    else $error("header last flag does not match payload length");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == mhd_pkg::KIND_PAYLOAD |-> out_tdata[HDR_BITS-1:0] == '0)
    else $error("payload result carries header words");

  a_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == mhd_pkg::KIND_HEADER |->
      out_tdata[mhd_pkg::DATA_W-1 -: mhd_pkg::BYTE_W] == '0)
    else $error("header result carries a payload byte");

endmodule

bind message_header_deframer mhd_checker u_mhd_checker (.*);
